/* rtl/mpa_pkg.sv */
// Shared definitions for the 2D max pooling block with argmax.
// Holds default sizes, register indexes and the structs passed between modules.
// No dependencies.
package mpa_pkg;

  localparam int unsigned MAX_WIDTH   = 1024;
  localparam int unsigned MAX_POOL    = 4;
  localparam int unsigned SAMPLE_BITS = 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_DIM_W  = 3;
  localparam int unsigned POS_OUT_W  = 10;

  localparam logic [CFG_DIM_W-1:0] POOL_RESET   = 3'd2;
  localparam logic [CFG_DIM_W-1:0] STRIDE_RESET = 3'd2;
  localparam int unsigned          IMAGE_RESET  = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_H   = 3'd0,
    CFG_POOL_W   = 3'd1,
    CFG_STRIDE_H = 3'd2,
    CFG_STRIDE_W = 3'd3,
    CFG_IMAGE_H  = 3'd4,
    CFG_IMAGE_W  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] pool_h;
    logic [CFG_DIM_W-1:0] pool_w;
    logic [CFG_DIM_W-1:0] stride_h;
    logic [CFG_DIM_W-1:0] stride_w;
  } pool_cfg_t;

  typedef struct packed {
    logic hit;
    logic seed;
    logic last;
    logic done;
  } win_flags_t;

  // Zero reads as one and values above the limit saturate.
  function automatic int unsigned clamp_cfg(int unsigned value, int unsigned limit);
    int unsigned res;
    res = value;
    if (value == 0) begin
      res = 1;
    end else if (value > limit) begin
      res = limit;
    end
    return res;
  endfunction

endpackage

/* rtl/mpa_store.sv */
// Partial maximum store: one write port and one registered read port.
// Holds value, row and column of each open window. Uses no package items.
module mpa_store #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned DataW = 36,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mpa_window_unit.sv */
// Window geometry unit: for one candidate window offset it decides whether the
// current sample lies in that window and where the window lives in the store.
// Depends on mpa_pkg.
module mpa_window_unit #(
  parameter int unsigned MaxWidth = mpa_pkg::MAX_WIDTH,
  parameter int unsigned MaxPool  = mpa_pkg::MAX_POOL,
  localparam int unsigned PosW  = $clog2(MaxWidth),
  localparam int unsigned DimW  = PosW + 2,
  localparam int unsigned SlotW = (MaxPool > 1) ? $clog2(MaxPool) : 1,
  localparam int unsigned AddrW = $clog2(MaxPool * MaxWidth)
) (
  input  logic [SlotW-1:0]        k_i,
  input  logic [SlotW-1:0]        j_i,
  input  logic [PosW-1:0]         row_i,
  input  logic [PosW-1:0]         col_i,
  input  logic [2:0]              row_phase_i,
  input  logic [2:0]              col_phase_i,
  input  logic [PosW-1:0]         row_base_i,
  input  logic [PosW-1:0]         col_base_i,
  input  logic [SlotW-1:0]        row_slot_i,
  input  mpa_pkg::pool_cfg_t      pool_i,
  input  logic [DimW-1:0]         img_h_i,
  input  logic [DimW-1:0]         img_w_i,
  output mpa_pkg::win_flags_t     flags_o,
  output logic [AddrW-1:0]        addr_o,
  output logic [PosW-1:0]         win_row_o,
  output logic [PosW-1:0]         win_col_o
);

  import mpa_pkg::*;

  logic [DimW-1:0]  row_off, row_start, row_org, row_end_full, row_end;
  logic [DimW-1:0]  col_off, col_start, col_org, col_end_full, col_end;
  logic             row_in, row_ok, row_first, row_last, row_done;
  logic             col_in, col_ok, col_first, col_last, col_done;
  logic [SlotW:0]   slot_diff;
  logic [SlotW-1:0] slot;

  assign row_off      = DimW'(k_i) * DimW'(pool_i.stride_h);
  assign row_start    = DimW'(row_i) - DimW'(row_phase_i);
  assign row_in       = row_off <= row_start;
  assign row_org      = row_start - row_off;
  assign row_end_full = row_org + DimW'(pool_i.pool_h);
  assign row_ok       = row_in && (row_org + DimW'(pool_i.stride_h) <= img_h_i)
                        && (DimW'(row_i) < row_end_full);
  assign row_end      = (row_end_full > img_h_i) ? img_h_i : row_end_full;
  assign row_first    = DimW'(row_i) == row_org;
  assign row_last     = DimW'(row_i) + DimW'(1) == row_end;
  assign row_done     = row_org + DimW'(pool_i.stride_h) + DimW'(pool_i.stride_h) > img_h_i;

  assign col_off      = DimW'(j_i) * DimW'(pool_i.stride_w);
  assign col_start    = DimW'(col_i) - DimW'(col_phase_i);
  assign col_in       = col_off <= col_start;
  assign col_org      = col_start - col_off;
  assign col_end_full = col_org + DimW'(pool_i.pool_w);
  assign col_ok       = col_in && (col_org + DimW'(pool_i.stride_w) <= img_w_i)
                        && (DimW'(col_i) < col_end_full);
  assign col_end      = (col_end_full > img_w_i) ? img_w_i : col_end_full;
  assign col_first    = DimW'(col_i) == col_org;
  assign col_last     = DimW'(col_i) + DimW'(1) == col_end;
  assign col_done     = col_org + DimW'(pool_i.stride_w) + DimW'(pool_i.stride_w) > img_w_i;

  // The window row is kept modulo the number of buffered window rows.
  assign slot_diff = {1'b0, row_slot_i} - (SlotW + 1)'(k_i);
  assign slot      = slot_diff[SlotW] ? SlotW'(slot_diff + (SlotW + 1)'(MaxPool))
                                      : slot_diff[SlotW-1:0];

  assign win_row_o = row_base_i - PosW'(k_i);
  assign win_col_o = col_base_i - PosW'(j_i);
  assign addr_o    = AddrW'(slot) * AddrW'(MaxWidth) + AddrW'(win_col_o);

  assign flags_o.hit  = row_ok && col_ok;
  assign flags_o.seed = row_first && col_first;
  assign flags_o.last = row_last && col_last;
  assign flags_o.done = row_done && col_done;

endmodule

/* rtl/max_pool_2d_argmax.sv */
// Top level of the 2D max pooling block with argmax.
// Contains the sequencer, the compare stage and the output register.
// Depends on mpa_pkg, mpa_window_unit and mpa_store.

// Samples arrive in raster order and each one is checked against every window
// offset that can contain it, pool_height * pool_width offsets in all, one offset
// per cycle while the offsets miss it; each window that does contain the sample
// adds a step for the compare and write-back of its store read. An accept step
// comes first and a closing step last, and the block takes no new sample until it
// is through with the current one. The single port pair of the partial maximum
// store and the shared window unit are why the offsets are checked one at a time.
// Results that find the output register full wait for it. A configuration write
// to a mapped register index restarts the plane at row 0, column 0.
module max_pool_2d_argmax #(
  parameter int unsigned MaxWidth   = mpa_pkg::MAX_WIDTH,
  parameter int unsigned MaxPool    = mpa_pkg::MAX_POOL,
  parameter int unsigned SampleBits = mpa_pkg::SAMPLE_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mpa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mpa_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [SampleBits-1:0]     sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [SampleBits-1:0]     max_value_o,
  output logic [mpa_pkg::POS_OUT_W-1:0]    arg_row_o,
  output logic [mpa_pkg::POS_OUT_W-1:0]    arg_col_o,
  output logic [mpa_pkg::POS_OUT_W-1:0]    out_row_o,
  output logic [mpa_pkg::POS_OUT_W-1:0]    out_col_o,
  output logic                             last_of_run_o,
  output logic                             plane_done_o
);

  import mpa_pkg::*;

  localparam int unsigned PosW   = $clog2(MaxWidth);
  localparam int unsigned DimW   = PosW + 2;
  localparam int unsigned SlotW  = (MaxPool > 1) ? $clog2(MaxPool) : 1;
  localparam int unsigned Depth  = MaxPool * MaxWidth;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned EntryW = SampleBits + 2 * PosW;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EVAL  = 4'b0010,
    ST_UPD   = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  state_e                       state_q, state_d;
  pool_cfg_t                    pool_q, pool_d;
  logic [DimW-1:0]              img_h_q, img_h_d, img_w_q, img_w_d;
  logic [PosW-1:0]              row_q, row_d, col_q, col_d;
  logic [2:0]                   row_phase_q, row_phase_d, col_phase_q, col_phase_d;
  logic [PosW-1:0]              row_base_q, row_base_d, col_base_q, col_base_d;
  logic [SlotW-1:0]             row_slot_q, row_slot_d;
  logic [SlotW-1:0]             k_q, k_d, j_q, j_d;
  logic signed [SampleBits-1:0] sample_q, sample_d;

  win_flags_t                   win_flags, cand_flags_q, cand_flags_d;
  logic [AddrW-1:0]             win_addr, cand_addr_q, cand_addr_d;
  logic [PosW-1:0]              win_row, win_col;
  logic [PosW-1:0]              cand_row_q, cand_row_d, cand_col_q, cand_col_d;

  logic                         store_we, store_re;
  logic [EntryW-1:0]            store_rdata, entry_new;
  logic signed [SampleBits-1:0] rd_value;
  logic                         take;

  logic                         hold_valid_q, hold_valid_d;
  logic signed [SampleBits-1:0] hold_value_q, hold_value_d;
  logic [POS_OUT_W-1:0]         hold_arow_q, hold_arow_d, hold_acol_q, hold_acol_d;
  logic [POS_OUT_W-1:0]         hold_orow_q, hold_orow_d, hold_ocol_q, hold_ocol_d;
  logic                         hold_done_q, hold_done_d;

  logic                         out_valid_q, out_valid_d;
  logic signed [SampleBits-1:0] out_value_q, out_value_d;
  logic [POS_OUT_W-1:0]         out_arow_q, out_arow_d, out_acol_q, out_acol_d;
  logic [POS_OUT_W-1:0]         out_orow_q, out_orow_d, out_ocol_q, out_ocol_d;
  logic                         out_last_q, out_last_d, out_done_q, out_done_d;

  logic                         out_free, next_cand, pos_advance;

  mpa_window_unit #(
    .MaxWidth (MaxWidth),
    .MaxPool  (MaxPool)
  ) u_window (
    .k_i         (k_q),
    .j_i         (j_q),
    .row_i       (row_q),
    .col_i       (col_q),
    .row_phase_i (row_phase_q),
    .col_phase_i (col_phase_q),
    .row_base_i  (row_base_q),
    .col_base_i  (col_base_q),
    .row_slot_i  (row_slot_q),
    .pool_i      (pool_q),
    .img_h_i     (img_h_q),
    .img_w_i     (img_w_q),
    .flags_o     (win_flags),
    .addr_o      (win_addr),
    .win_row_o   (win_row),
    .win_col_o   (win_col)
  );

  mpa_store #(
    .Depth (Depth),
    .DataW (EntryW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (cand_addr_q),
    .wdata_i (entry_new),
    .re_i    (store_re),
    .raddr_i (win_addr),
    .rdata_o (store_rdata)
  );

  assign rd_value  = store_rdata[EntryW-1 -: SampleBits];
  assign take      = cand_flags_q.seed || (sample_q > rd_value);
  assign entry_new = take ? {sample_q, row_q, col_q} : store_rdata;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    j_d          = j_q;
    sample_d     = sample_q;
    cand_flags_d = cand_flags_q;
    cand_addr_d  = cand_addr_q;
    cand_row_d   = cand_row_q;
    cand_col_d   = cand_col_q;
    hold_valid_d = hold_valid_q;
    hold_value_d = hold_value_q;
    hold_arow_d  = hold_arow_q;
    hold_acol_d  = hold_acol_q;
    hold_orow_d  = hold_orow_q;
    hold_ocol_d  = hold_ocol_q;
    hold_done_d  = hold_done_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_value_d  = out_value_q;
    out_arow_d   = out_arow_q;
    out_acol_d   = out_acol_q;
    out_orow_d   = out_orow_q;
    out_ocol_d   = out_ocol_q;
    out_last_d   = out_last_q;
    out_done_d   = out_done_q;
    store_we     = 1'b0;
    store_re     = 1'b0;
    next_cand    = 1'b0;
    pos_advance  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sample_d = sample_i;
          k_d      = SlotW'(pool_q.pool_h - 3'd1);
          j_d      = SlotW'(pool_q.pool_w - 3'd1);
          state_d  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cand_flags_d = win_flags;
        cand_addr_d  = win_addr;
        cand_row_d   = win_row;
        cand_col_d   = win_col;
        if (win_flags.hit) begin
          store_re = 1'b1;
          state_d  = ST_UPD;
        end else begin
          next_cand = 1'b1;
        end
      end
      ST_UPD: begin
        if (!cand_flags_q.last || !hold_valid_q || out_free) begin
          store_we  = 1'b1;
          next_cand = 1'b1;
          if (cand_flags_q.last) begin
            if (hold_valid_q) begin
              out_valid_d = 1'b1;
              out_value_d = hold_value_q;
              out_arow_d  = hold_arow_q;
              out_acol_d  = hold_acol_q;
              out_orow_d  = hold_orow_q;
              out_ocol_d  = hold_ocol_q;
              out_done_d  = hold_done_q;
              out_last_d  = 1'b0;
            end
            hold_valid_d = 1'b1;
            hold_value_d = entry_new[EntryW-1 -: SampleBits];
            hold_arow_d  = POS_OUT_W'(entry_new[2*PosW-1 -: PosW]);
            hold_acol_d  = POS_OUT_W'(entry_new[PosW-1:0]);
            hold_orow_d  = POS_OUT_W'(cand_row_q);
            hold_ocol_d  = POS_OUT_W'(cand_col_q);
            hold_done_d  = cand_flags_q.done;
          end
        end
      end
      ST_FLUSH: begin
        if (!hold_valid_q || out_free) begin
          pos_advance = 1'b1;
          state_d     = ST_IDLE;
          if (hold_valid_q) begin
            out_valid_d  = 1'b1;
            out_value_d  = hold_value_q;
            out_arow_d   = hold_arow_q;
            out_acol_d   = hold_acol_q;
            out_orow_d   = hold_orow_q;
            out_ocol_d   = hold_ocol_q;
            out_done_d   = hold_done_q;
            out_last_d   = 1'b1;
            hold_valid_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (next_cand) begin
      if (j_q != '0) begin
        j_d     = j_q - SlotW'(1);
        state_d = ST_EVAL;
      end else if (k_q != '0) begin
        k_d     = k_q - SlotW'(1);
        j_d     = SlotW'(pool_q.pool_w - 3'd1);
        state_d = ST_EVAL;
      end else begin
        state_d = ST_FLUSH;
      end
    end
  end

  always_comb begin
    pool_d      = pool_q;
    img_h_d     = img_h_q;
    img_w_d     = img_w_q;
    row_d       = row_q;
    col_d       = col_q;
    row_phase_d = row_phase_q;
    col_phase_d = col_phase_q;
    row_base_d  = row_base_q;
    col_base_d  = col_base_q;
    row_slot_d  = row_slot_q;

    if (pos_advance) begin
      if (DimW'(col_q) + DimW'(1) >= img_w_q) begin
        col_d       = '0;
        col_phase_d = '0;
        col_base_d  = '0;
        if (DimW'(row_q) + DimW'(1) >= img_h_q) begin
          row_d       = '0;
          row_phase_d = '0;
          row_base_d  = '0;
          row_slot_d  = '0;
        end else begin
          row_d = row_q + PosW'(1);
          if (row_phase_q + 3'd1 == pool_q.stride_h) begin
            row_phase_d = '0;
            row_base_d  = row_base_q + PosW'(1);
            row_slot_d  = (row_slot_q == SlotW'(MaxPool - 1)) ? '0 : row_slot_q + SlotW'(1);
          end else begin
            row_phase_d = row_phase_q + 3'd1;
          end
        end
      end else begin
        col_d = col_q + PosW'(1);
        if (col_phase_q + 3'd1 == pool_q.stride_w) begin
          col_phase_d = '0;
          col_base_d  = col_base_q + PosW'(1);
        end else begin
          col_phase_d = col_phase_q + 3'd1;
        end
      end
    end

    if (cfg_we_i && (cfg_idx_i <= CFG_IMAGE_W)) begin
      row_d       = '0;
      col_d       = '0;
      row_phase_d = '0;
      col_phase_d = '0;
      row_base_d  = '0;
      col_base_d  = '0;
      row_slot_d  = '0;
      unique case (cfg_idx_i)
        CFG_POOL_H:   pool_d.pool_h   = 3'(clamp_cfg(int'(cfg_wdata_i[2:0]), MaxPool));
        CFG_POOL_W:   pool_d.pool_w   = 3'(clamp_cfg(int'(cfg_wdata_i[2:0]), MaxPool));
        CFG_STRIDE_H: pool_d.stride_h = 3'(clamp_cfg(int'(cfg_wdata_i[2:0]), MaxPool));
        CFG_STRIDE_W: pool_d.stride_w = 3'(clamp_cfg(int'(cfg_wdata_i[2:0]), MaxPool));
        CFG_IMAGE_H:  img_h_d = DimW'(clamp_cfg(int'(cfg_wdata_i), MaxWidth));
        CFG_IMAGE_W:  img_w_d = DimW'(clamp_cfg(int'(cfg_wdata_i), MaxWidth));
        default: begin
          pool_d = pool_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pool_q       <= '{pool_h: POOL_RESET, pool_w: POOL_RESET,
                        stride_h: STRIDE_RESET, stride_w: STRIDE_RESET};
      img_h_q      <= DimW'(clamp_cfg(IMAGE_RESET, MaxWidth));
      img_w_q      <= DimW'(clamp_cfg(IMAGE_RESET, MaxWidth));
      row_q        <= '0;
      col_q        <= '0;
      row_phase_q  <= '0;
      col_phase_q  <= '0;
      row_base_q   <= '0;
      col_base_q   <= '0;
      row_slot_q   <= '0;
      k_q          <= '0;
      j_q          <= '0;
      cand_flags_q <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pool_q       <= pool_d;
      img_h_q      <= img_h_d;
      img_w_q      <= img_w_d;
      row_q        <= row_d;
      col_q        <= col_d;
      row_phase_q  <= row_phase_d;
      col_phase_q  <= col_phase_d;
      row_base_q   <= row_base_d;
      col_base_q   <= col_base_d;
      row_slot_q   <= row_slot_d;
      k_q          <= k_d;
      j_q          <= j_d;
      cand_flags_q <= cand_flags_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q     <= sample_d;
    cand_addr_q  <= cand_addr_d;
    cand_row_q   <= cand_row_d;
    cand_col_q   <= cand_col_d;
    hold_value_q <= hold_value_d;
    hold_arow_q  <= hold_arow_d;
    hold_acol_q  <= hold_acol_d;
    hold_orow_q  <= hold_orow_d;
    hold_ocol_q  <= hold_ocol_d;
    hold_done_q  <= hold_done_d;
    out_value_q  <= out_value_d;
    out_arow_q   <= out_arow_d;
    out_acol_q   <= out_acol_d;
    out_orow_q   <= out_orow_d;
    out_ocol_q   <= out_ocol_d;
    out_last_q   <= out_last_d;
    out_done_q   <= out_done_d;
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign max_value_o   = out_value_q;
  assign arg_row_o     = out_arow_q;
  assign arg_col_o     = out_acol_q;
  assign out_row_o     = out_orow_q;
  assign out_col_o     = out_ocol_q;
  assign last_of_run_o = out_last_q;
  assign plane_done_o  = out_done_q;

`ifndef ASSERT_OFF
  // A held result must be released before the block takes the next sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !hold_valid_q)
    else $error("held result left behind at end of transaction");

  // The compare step always follows a store read issued by the geometry step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> ($past(state_q) == ST_EVAL || $past(state_q) == ST_UPD))
    else $error("compare step entered without a store read");

  // Phase counters stay below their strides.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_phase_q < pool_q.stride_w) && (row_phase_q < pool_q.stride_h))
    else $error("window phase counter out of range");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for max_pool_2d_argmax: a directed table, the start of a wide row
// and random planes, checked against known results or a pooling predictor in the bench.
// Depends on mpa_pkg and the RTL of the block; reads no files.
module tb_top;
  import mpa_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SWEEP_ITEMS    = 96;
  localparam int unsigned RANDOM_ITEMS   = 310;
  localparam int unsigned PHASE_ITEMS    = 80;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd6;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] max_value;
    logic [POS_OUT_W-1:0]          arg_row;
    logic [POS_OUT_W-1:0]          arg_col;
    logic [POS_OUT_W-1:0]          out_row;
    logic [POS_OUT_W-1:0]          out_col;
    logic                          last_of_run;
    logic                          plane_done;
  } pool_result_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [POS_OUT_W-1:0]          row;
    logic [POS_OUT_W-1:0]          col;
  } partial_max_t;

  typedef struct packed {
    logic                          is_write;
    cfg_idx_e                      reg_idx;
    logic [CFG_DATA_W-1:0]         reg_data;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          typed;
    pool_result_t                  result;
  } directed_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]         cfg_wdata_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] sample_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] max_value_o;
  logic [POS_OUT_W-1:0]          arg_row_o;
  logic [POS_OUT_W-1:0]          arg_col_o;
  logic [POS_OUT_W-1:0]          out_row_o;
  logic [POS_OUT_W-1:0]          out_col_o;
  logic                          last_of_run_o;
  logic                          plane_done_o;

  int unsigned pool_h = POOL_RESET;
  int unsigned pool_w = POOL_RESET;
  int unsigned stride_h = STRIDE_RESET;
  int unsigned stride_w = STRIDE_RESET;
  int unsigned image_h = IMAGE_RESET;
  int unsigned image_w = IMAGE_RESET;
  int unsigned pos_row = 0;
  int unsigned pos_col = 0;
  partial_max_t partial_max [MAX_POOL*MAX_WIDTH];

  pool_result_t expected_windows [$];
  directed_row_t directed_rows [$];
  bit failed = 1'b0;
  bit quiet = 1'b0;
  bit writes_open = 1'b0;
  int unsigned stall_left = 0;
  int unsigned idle_count = 0;

  max_pool_2d_argmax u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .sample_i,
    .out_valid_o,
    .out_stall_i,
    .max_value_o,
    .arg_row_o,
    .arg_col_o,
    .out_row_o,
    .out_col_o,
    .last_of_run_o,
    .plane_done_o
  );

  always #4 clk_i = ~clk_i;

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    int unsigned dim;
    int unsigned size;
    dim = data[CFG_DIM_W-1:0];
    dim = (dim == 0) ? 1 : ((dim > MAX_POOL) ? MAX_POOL : dim);
    size = data;
    size = (size == 0) ? 1 : ((size > MAX_WIDTH) ? MAX_WIDTH : size);
    case (idx)
      CFG_POOL_H:   pool_h = dim;
      CFG_POOL_W:   pool_w = dim;
      CFG_STRIDE_H: stride_h = dim;
      CFG_STRIDE_W: stride_w = dim;
      CFG_IMAGE_H:  image_h = size;
      CFG_IMAGE_W:  image_w = size;
      default:      return;
    endcase
    pos_row = 0;
    pos_col = 0;
  endfunction

  // Updates every window that holds the current position and returns those that close on it.
  function automatic void predict_pooling(input logic signed [SAMPLE_BITS-1:0] x,
                                          output pool_result_t closed [$]);
    int unsigned out_h, out_w, base_r, base_c, wr, wc, r0, c0, rend, cend, slot;
    pool_result_t res;
    closed = {};
    out_h = image_h / stride_h;
    out_w = image_w / stride_w;
    base_r = pos_row / stride_h;
    base_c = pos_col / stride_w;
    for (int k = MAX_POOL - 1; k >= 0; k--) begin
      if (k > base_r) continue;
      wr = base_r - k;
      r0 = wr * stride_h;
      if (wr >= out_h || pos_row >= r0 + pool_h) continue;
      rend = (r0 + pool_h > image_h) ? image_h : r0 + pool_h;
      for (int j = MAX_POOL - 1; j >= 0; j--) begin
        if (j > base_c) continue;
        wc = base_c - j;
        c0 = wc * stride_w;
        if (wc >= out_w || pos_col >= c0 + pool_w) continue;
        cend = (c0 + pool_w > image_w) ? image_w : c0 + pool_w;
        slot = (wr % MAX_POOL) * MAX_WIDTH + wc;
        if ((pos_row == r0 && pos_col == c0) || x > partial_max[slot].value) begin
          partial_max[slot].value = x;
          partial_max[slot].row = POS_OUT_W'(pos_row);
          partial_max[slot].col = POS_OUT_W'(pos_col);
        end
        if (pos_row == rend - 1 && pos_col == cend - 1) begin
          res.max_value = partial_max[slot].value;
          res.arg_row = partial_max[slot].row;
          res.arg_col = partial_max[slot].col;
          res.out_row = POS_OUT_W'(wr);
          res.out_col = POS_OUT_W'(wc);
          res.last_of_run = 1'b0;
          res.plane_done = (wr == out_h - 1) && (wc == out_w - 1);
          closed.push_back(res);
        end
      end
    end
    if (closed.size() != 0) closed[closed.size()-1].last_of_run = 1'b1;
    pos_col++;
    if (pos_col >= image_w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= image_h) pos_row = 0;
    end
  endfunction

  function automatic directed_row_t reg_row(cfg_idx_e idx, int unsigned data);
    directed_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.reg_idx = idx;
    row.reg_data = CFG_DATA_W'(data);
    return row;
  endfunction

  function automatic directed_row_t sample_row(logic signed [SAMPLE_BITS-1:0] value);
    directed_row_t row;
    row = '0;
    row.sample = value;
    return row;
  endfunction

  function automatic directed_row_t known_row(logic signed [SAMPLE_BITS-1:0] value, int max_value,
                                              int arg_row, int arg_col, int out_row, int out_col,
                                              bit done);
    directed_row_t row;
    row = sample_row(value);
    row.typed = 1'b1;
    row.result.max_value = SAMPLE_BITS'(max_value);
    row.result.arg_row = POS_OUT_W'(arg_row);
    row.result.arg_col = POS_OUT_W'(arg_col);
    row.result.out_row = POS_OUT_W'(out_row);
    row.result.out_col = POS_OUT_W'(out_col);
    row.result.last_of_run = 1'b1;
    row.result.plane_done = done;
    return row;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endfunction

  // The block is idle only once every window has come out and the last sample has retired.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_windows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, int unsigned data);
    if (!writes_open) settle();
    writes_open = 1'b1;
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= CFG_DATA_W'(data);
    @(posedge clk_i);
    apply_register(idx, CFG_DATA_W'(data));
  endtask

  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] value, logic typed,
                             pool_result_t known);
    pool_result_t found [$];
    if (writes_open) begin
      cfg_we_i <= 1'b0;
      writes_open = 1'b0;
    end
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_pooling(value, found);
    if (typed) begin
      expected_windows.push_back(known);
    end else begin
      foreach (found[i]) expected_windows.push_back(found[i]);
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(1, 7);
    end
    out_stall_i <= (stall_left != 0);
  end

  always @(posedge clk_i) begin
    pool_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_windows.size() == 0) begin
        $display("%0t: unexpected window result, out_row %0d out_col %0d max_value %0d",
                 $time, out_row_o, out_col_o, max_value_o);
        failed = 1'b1;
      end else begin
        want = expected_windows.pop_front();
        check_field("max_value", want.max_value, max_value_o);
        check_field("arg_row", want.arg_row, arg_row_o);
        check_field("arg_col", want.arg_col, arg_col_o);
        check_field("out_row", want.out_row, out_row_o);
        check_field("out_col", want.out_col, out_col_o);
        check_field("last_of_run", want.last_of_run, last_of_run_o);
        check_field("plane_done", want.plane_done, plane_done_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_count = 0;
    end else begin
      idle_count++;
    end
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic signed [SAMPLE_BITS-1:0] value;
    int unsigned random_items;
    int unsigned count;
    int unsigned plane;
    random_items = 0;
    foreach (partial_max[i]) partial_max[i] = '0;

    directed_rows = '{
      // One row of two 1x2 windows: both sample extremes, then a tie kept at its first place.
      reg_row(CFG_POOL_H, 1), reg_row(CFG_POOL_W, 2), reg_row(CFG_STRIDE_H, 1),
      reg_row(CFG_STRIDE_W, 2), reg_row(CFG_IMAGE_H, 0), reg_row(CFG_IMAGE_W, 4),
      sample_row(16'sh7FFF), known_row(16'sh8000, 32767, 0, 0, 0, 0, 1'b0),
      sample_row(16'sh8000), known_row(16'sh8000, -32768, 0, 2, 0, 1, 1'b1),
      // A 4x4 plane with saturated 4x4 windows at stride 1: all sixteen close on the last sample.
      reg_row(CFG_POOL_H, 5), reg_row(CFG_POOL_W, 4), reg_row(CFG_STRIDE_H, 1),
      reg_row(CFG_STRIDE_W, 0), reg_row(CFG_IMAGE_H, 4), reg_row(CFG_IMAGE_W, 4),
      sample_row(16'sh0000), sample_row(16'shFFFF), sample_row(16'sh0100), sample_row(16'sh7FFE),
      sample_row(16'sh8001), sample_row(16'sh0040), sample_row(16'sh7FFE), sample_row(16'sh0001),
      sample_row(16'shC000), sample_row(16'sh3FFF), sample_row(16'sh0100), sample_row(16'sh8000),
      sample_row(16'sh5555), sample_row(16'shAAAA), sample_row(16'sh7FFF), sample_row(16'sh0000),
      // Pool smaller than stride: the two columns after the window are ignored.
      reg_row(CFG_POOL_H, 1), reg_row(CFG_POOL_W, 1), reg_row(CFG_STRIDE_H, 1),
      reg_row(CFG_STRIDE_W, 3), reg_row(CFG_IMAGE_H, 1), reg_row(CFG_IMAGE_W, 3),
      known_row(16'sh1234, 16'sh1234, 0, 0, 0, 0, 1'b1), sample_row(16'shFFFB),
      sample_row(16'sh0009)
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        write_register(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        send_sample(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].result);
      end
    end

    // The start of a single full-width row; the sizes saturate or read zero as one.
    write_register(CFG_POOL_H, $urandom_range(1, 4));
    write_register(CFG_POOL_W, 4);
    write_register(CFG_STRIDE_H, 1);
    write_register(CFG_STRIDE_W, 1);
    write_register(CFG_IMAGE_H, 0);
    write_register(CFG_IMAGE_W, 2047);
    repeat (SWEEP_ITEMS) send_sample(SAMPLE_BITS'($urandom), 1'b0, '0);

    while (random_items < RANDOM_ITEMS) begin
      if (random_items + PHASE_ITEMS >= RANDOM_ITEMS) quiet = 1'b1;
      if (random_items != 0 && $urandom_range(0, 4) == 0) begin
        // An unmapped index must not restart the plane in progress.
        write_register(CFG_UNMAPPED | CFG_IDX_W'($urandom_range(0, 1)), $urandom_range(0, 2047));
        count = $urandom_range(10, 40);
      end else begin
        write_register(CFG_POOL_H, $urandom_range(0, 2047));
        write_register(CFG_POOL_W, $urandom_range(0, 2047));
        write_register(CFG_STRIDE_H, $urandom_range(0, 2047));
        write_register(CFG_STRIDE_W, $urandom_range(0, 2047));
        write_register(CFG_IMAGE_H,
                       ($urandom_range(0, 4) == 0) ? $urandom_range(15, 48) : $urandom_range(0, 14));
        write_register(CFG_IMAGE_W,
                       ($urandom_range(0, 4) == 0) ? $urandom_range(15, 48) : $urandom_range(0, 14));
        plane = image_h * image_w;
        count = 2 * plane + $urandom_range(0, plane);
        if (count > PHASE_ITEMS) count = PHASE_ITEMS;
      end
      repeat (count) begin
        case ($urandom_range(0, 3))
          0:       value = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
          1:       value = SAMPLE_BITS'($urandom_range(0, 3));
          default: value = SAMPLE_BITS'($urandom);
        endcase
        send_sample(value, 1'b0, '0);
        random_items++;
      end
    end

    in_valid_i <= 1'b0;
    while (expected_windows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* max_pool_2d_argmax.f */
rtl/mpa_pkg.sv
rtl/mpa_store.sv
rtl/mpa_window_unit.sv
rtl/max_pool_2d_argmax.sv
tb/tb_top.sv
